// ===== rtl/qfts_pkg.sv =====
// ----------------------------------------------------------------------------
// qfts_pkg
// Shared constants and types for the queue built from two stacks: field
// widths, operation and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package qfts_pkg;

    localparam int DEFAULT_STACK_DEPTH = 128;
    localparam int DATA_W              = 32;
    localparam int STATUS_W            = 2;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_code_t;

    typedef struct packed {
        logic         capture;
        logic         push;
        logic         move_issue;
        logic         pop_issue;
        logic         load;
        logic         load_from_mem;
        status_code_t load_code;
    } qfts_cmd_t;

    typedef struct packed {
        logic item_kind;
        logic inbox_full;
        logic inbox_empty;
        logic outbox_empty;
        logic move_pending;
        logic out_ready;
    } qfts_sts_t;

endpackage

// ===== rtl/qfts_ctrl.sv =====
// ----------------------------------------------------------------------------
// qfts_ctrl
// Controller state machine: sequences enqueue, refill and dequeue steps
// and issues commands to the datapath.
// ----------------------------------------------------------------------------
module qfts_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  qfts_pkg::qfts_sts_t sts,
    output qfts_pkg::qfts_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_MOVE = 4'b0100,
        S_POP  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        cmd.capture       = 1'b0;
        cmd.push          = 1'b0;
        cmd.move_issue    = 1'b0;
        cmd.pop_issue     = 1'b0;
        cmd.load          = 1'b0;
        cmd.load_from_mem = 1'b0;
        cmd.load_code     = qfts_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.item_kind == qfts_pkg::KIND_ENQ)
                begin
                    if (sts.out_ready)
                    begin
                        cmd.load = 1'b1;
                        if (sts.inbox_full)
                        begin
                            cmd.load_code = qfts_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end
                else if (!sts.outbox_empty)
                begin
                    cmd.pop_issue = 1'b1;
                    state_next    = S_POP;
                end
                else if (!sts.inbox_empty)
                begin
                    state_next = S_MOVE;
                end
                else if (sts.out_ready)
                begin
                    cmd.load      = 1'b1;
                    cmd.load_code = qfts_pkg::ST_EMPTY;
                    state_next    = S_IDLE;
                end
            end
            S_MOVE:
            begin
                cmd.move_issue = !sts.inbox_empty;
                if (sts.inbox_empty && !sts.move_pending)
                begin
                    state_next = S_EXEC;
                end
            end
            S_POP:
            begin
                if (sts.out_ready)
                begin
                    cmd.load          = 1'b1;
                    cmd.load_from_mem = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/qfts_datapath.sv =====
// ----------------------------------------------------------------------------
// qfts_datapath
// Inbox and outbox stack memories with their counts, the captured item and
// the output register.
// ----------------------------------------------------------------------------
module qfts_datapath
#(
    parameter int STACK_DEPTH = qfts_pkg::DEFAULT_STACK_DEPTH
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                kind,
    input  logic signed [qfts_pkg::DATA_W-1:0]  data_value,
    input  qfts_pkg::qfts_cmd_t                 cmd,
    output qfts_pkg::qfts_sts_t                 sts,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [qfts_pkg::DATA_W-1:0]  result_value,
    output logic [qfts_pkg::STATUS_W-1:0]       status
);

    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    logic [qfts_pkg::DATA_W-1:0] inbox_mem  [STACK_DEPTH];
    logic [qfts_pkg::DATA_W-1:0] outbox_mem [STACK_DEPTH];

    logic [CNT_W-1:0]                   icnt_reg;
    logic [CNT_W-1:0]                   icnt_next;
    logic [CNT_W-1:0]                   ocnt_reg;
    logic [CNT_W-1:0]                   ocnt_next;
    logic [CNT_W-1:0]                   icnt_dec;
    logic [CNT_W-1:0]                   ocnt_dec;
    logic                               pend_reg;
    logic                               item_kind_reg;
    logic [qfts_pkg::DATA_W-1:0]        item_data_reg;
    logic [qfts_pkg::DATA_W-1:0]        inbox_rdata_reg;
    logic [qfts_pkg::DATA_W-1:0]        outbox_rdata_reg;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [qfts_pkg::DATA_W-1:0]        result_reg;
    logic [qfts_pkg::STATUS_W-1:0]      status_reg;
    logic                               out_ready;

    assign icnt_dec  = icnt_reg - ONE_CNT;
    assign ocnt_dec  = ocnt_reg - ONE_CNT;
    assign out_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        icnt_next = icnt_reg;
        if (cmd.push)
        begin
            icnt_next = icnt_reg + ONE_CNT;
        end
        else if (cmd.move_issue)
        begin
            icnt_next = icnt_dec;
        end
    end

    always_comb
    begin
        ocnt_next = ocnt_reg;
        if (pend_reg)
        begin
            ocnt_next = ocnt_reg + ONE_CNT;
        end
        else if (cmd.pop_issue)
        begin
            ocnt_next = ocnt_dec;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icnt_reg      <= '0;
            ocnt_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            icnt_reg      <= icnt_next;
            ocnt_reg      <= ocnt_next;
            pend_reg      <= cmd.move_issue;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_kind_reg <= kind;
            item_data_reg <= data_value;
        end
        if (cmd.load)
        begin
            result_reg <= cmd.load_from_mem ? outbox_rdata_reg : '0;
            status_reg <= cmd.load_code;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            inbox_mem[icnt_reg[IDX_W-1:0]] <= item_data_reg;
        end
        if (cmd.move_issue)
        begin
            inbox_rdata_reg <= inbox_mem[icnt_dec[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            outbox_mem[ocnt_reg[IDX_W-1:0]] <= inbox_rdata_reg;
        end
        if (cmd.pop_issue)
        begin
            outbox_rdata_reg <= outbox_mem[ocnt_dec[IDX_W-1:0]];
        end
    end

    assign sts.item_kind    = item_kind_reg;
    assign sts.inbox_full   = (icnt_reg == DEPTH_CNT);
    assign sts.inbox_empty  = (icnt_reg == '0);
    assign sts.outbox_empty = (ocnt_reg == '0);
    assign sts.move_pending = pend_reg;
    assign sts.out_ready    = out_ready;

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign status       = status_reg;

`ifndef SYNTHESIS
    a_no_push_during_move: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && (cmd.move_issue || pend_reg)))
        else $error("Inbox push overlaps a refill transfer.");

    a_refill_fits: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (ocnt_reg < DEPTH_CNT))
        else $error("Refill would overflow the outbox.");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_issue |-> (ocnt_reg != '0) && !pend_reg)
        else $error("Outbox pop issued while empty or refilling.");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (icnt_reg < DEPTH_CNT))
        else $error("Inbox push issued while full.");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> out_ready)
        else $error("Output register overwritten before its transfer.");
`endif

endmodule

// ===== rtl/queue_from_two_stacks_top.sv =====
// ----------------------------------------------------------------------------
// queue_from_two_stacks_top
// First-in first-out queue built from an inbox stack and an outbox stack.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  kind, data_value
// out      output     out_valid / out_stall result_value, status
//
// An item is first transferred in (S_IDLE) and then executed (S_EXEC).
// A dequeue that pops the outbox passes through S_POP for the registered
// memory read. A dequeue that finds the outbox empty first moves the n inbox
// entries across, at one entry a cycle, before the pop. Reset is asynchronous
// and active low and clears the counts; no memory clearing is needed. A
// stalled result is held in the output register while the next item is taken
// in; that item then waits until the register is free.
// ----------------------------------------------------------------------------
module queue_from_two_stacks_top
#(
    parameter int STACK_DEPTH = qfts_pkg::DEFAULT_STACK_DEPTH
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic signed [qfts_pkg::DATA_W-1:0]  data_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [qfts_pkg::DATA_W-1:0]  result_value,
    output logic [qfts_pkg::STATUS_W-1:0]       status
);

    qfts_pkg::qfts_cmd_t cmd;
    qfts_pkg::qfts_sts_t sts;

    qfts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    qfts_datapath
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .kind         (kind),
        .data_value   (data_value),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .status       (status)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the queue built from two stacks. A scoreboard class
// keeps its own inbox and outbox stacks and works out the reply to every
// accepted enqueue or dequeue. Plain tasks drive the request channel with
// directed corner cases first, then fill, drain and mixed bursts with random
// data, under three patterns of sender idling and receiver stalling. One long
// receiver hold-off makes the queue back up onto its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH         = qfts_pkg::DEFAULT_STACK_DEPTH;
    localparam int RANDOM_ITEMS  = 1680;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
    localparam int HOLD_CYCLES   = 400;

    typedef struct {
        logic signed [qfts_pkg::DATA_W-1:0] value;
        qfts_pkg::status_code_t             code;
    } reply_t;

    class queue_scoreboard;
        logic signed [qfts_pkg::DATA_W-1:0] inbox_mem [DEPTH];
        logic signed [qfts_pkg::DATA_W-1:0] outbox_mem [DEPTH];
        int unsigned                        inbox_used;
        int unsigned                        outbox_used;
        reply_t                             awaited [$];
        int unsigned                        mismatches;

        function new();
            inbox_used  = 0;
            outbox_used = 0;
            mismatches  = 0;
        endfunction

        function void note_request(logic req_kind,
                                   logic signed [qfts_pkg::DATA_W-1:0] req_value);
            reply_t r;
            r.value = '0;
            r.code  = qfts_pkg::ST_OK;
            if (req_kind == qfts_pkg::KIND_ENQ)
            begin
                if (inbox_used >= DEPTH)
                    r.code = qfts_pkg::ST_FULL;
                else
                begin
                    inbox_mem[inbox_used] = req_value;
                    inbox_used++;
                end
            end
            else
            begin
                if (outbox_used == 0)
                begin
                    while (inbox_used > 0)
                    begin
                        inbox_used--;
                        outbox_mem[outbox_used] = inbox_mem[inbox_used];
                        outbox_used++;
                    end
                end
                if (outbox_used == 0)
                    r.code = qfts_pkg::ST_EMPTY;
                else
                begin
                    outbox_used--;
                    r.value = outbox_mem[outbox_used];
                end
            end
            awaited.push_back(r);
        endfunction

        function void check_reply(logic signed [qfts_pkg::DATA_W-1:0] got_value,
                                  logic [qfts_pkg::STATUS_W-1:0] got_code);
            reply_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result: value %0d status %0d",
                             $time, got_value, got_code);
                return;
            end
            want = awaited.pop_front();
            if (got_value !== want.value || got_code !== want.code)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch: expected value %0d status %0d, ",
                              "got value %0d status %0d"},
                             $time, want.value, want.code, got_value, got_code);
            end
        endfunction

        function int unsigned waiting();
            return awaited.size();
        endfunction
    endclass

    logic                                 clk;
    logic                                 rst_n      = 1'b0;
    logic                                 in_valid   = 1'b0;
    logic                                 in_stall;
    logic                                 kind       = qfts_pkg::KIND_ENQ;
    logic signed [qfts_pkg::DATA_W-1:0]   data_value = '0;
    logic                                 out_valid;
    logic                                 out_stall  = 1'b0;
    logic signed [qfts_pkg::DATA_W-1:0]   result_value;
    logic [qfts_pkg::STATUS_W-1:0]        status;

    int                         phase          = 0;
    int                         send_idle_pct  = 0;
    int                         recv_stall_pct = 0;
    logic                       long_hold      = 1'b0;
    int                         cycle_count    = 0;
    queue_scoreboard            board          = new();

    queue_from_two_stacks_top #(.STACK_DEPTH(DEPTH)) dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .data_value   (data_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_reply(result_value, status);
        out_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        wait (phase == 2);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    function automatic logic signed [qfts_pkg::DATA_W-1:0] random_word();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic item_kind,
                             input logic signed [qfts_pkg::DATA_W-1:0] item_value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= item_kind;
        data_value <= item_value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(item_kind, item_value);
    endtask

    task automatic directed_items();
        send_item(qfts_pkg::KIND_DEQ, 32'h1234_5678);
        send_item(qfts_pkg::KIND_ENQ, 32'h8000_0000);
        send_item(qfts_pkg::KIND_ENQ, 32'h7FFF_FFFF);
        send_item(qfts_pkg::KIND_ENQ, 32'h0000_0000);
        send_item(qfts_pkg::KIND_ENQ, 32'hFFFF_FFFF);
        send_item(qfts_pkg::KIND_ENQ, 32'h5555_5555);
        send_item(qfts_pkg::KIND_ENQ, 32'hAAAA_AAAA);
        send_item(qfts_pkg::KIND_DEQ, 32'hFFFF_FFFF);
        send_item(qfts_pkg::KIND_DEQ, 32'h0000_0000);
        send_item(qfts_pkg::KIND_DEQ, 32'h8000_0000);
        send_item(qfts_pkg::KIND_ENQ, 32'h0000_0001);
        send_item(qfts_pkg::KIND_ENQ, 32'hFFFF_FFFE);
        send_item(qfts_pkg::KIND_DEQ, 32'h7FFF_FFFF);
        send_item(qfts_pkg::KIND_DEQ, 32'h5555_5555);
        send_item(qfts_pkg::KIND_DEQ, 32'hAAAA_AAAA);
        send_item(qfts_pkg::KIND_DEQ, 32'h0000_0000);
        send_item(qfts_pkg::KIND_DEQ, 32'h0000_0000);
        send_item(qfts_pkg::KIND_DEQ, 32'hFFFF_FFFF);
    endtask

    task automatic random_traffic(input int count);
        int   done_items;
        int   style;
        int   len;
        int   i;
        logic item_kind;
        done_items = 0;
        while (done_items < count)
        begin
            style = $urandom_range(9);
            if (style < 6)
                len = $urandom_range(16, DEPTH + 12);
            else
                len = $urandom_range(8, 60);
            for (i = 0; i < len && done_items < count; i++)
            begin
                if (style < 3)
                    item_kind = qfts_pkg::KIND_ENQ;
                else if (style < 6)
                    item_kind = qfts_pkg::KIND_DEQ;
                else
                    item_kind = 1'($urandom_range(1));
                send_item(item_kind, random_word());
                done_items++;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 12;
        recv_stall_pct = 77;
        directed_items();
        random_traffic(RANDOM_ITEMS / 3);

        phase          = 1;
        send_idle_pct  = 77;
        recv_stall_pct = 12;
        random_traffic(RANDOM_ITEMS / 3);

        phase          = 2;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_traffic(RANDOM_ITEMS / 3);

        in_valid <= 1'b0;
        while (board.waiting() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (board.mismatches == 0 && board.waiting() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
